/* rtl/scc_pkg.sv */
package scc_pkg;

	// Default depth of the queue between front and back.
	localparam int unsigned JobDepthDef = 4;

	// Number of size reply bytes counted before the image read goes out.
	localparam logic [3:0] SizeReplyLen = 4'd9;

	// Reset values of the configuration registers.
	localparam logic [3:0] IdleWaitRst = 4'd3;
	localparam logic [3:0] ShotWaitRst = 4'd5;

	// Configuration register indexes.
	localparam logic RegIdleWait = 1'b0;
	localparam logic RegShotWait = 1'b1;

	// Reply count saturation.
	localparam logic [3:0] CountMax = 4'd15;

	// Positions of the two length bytes in the size reply.
	localparam logic [3:0] SizeLenHiIdx = 4'd7;
	localparam logic [3:0] SizeLenLoIdx = 4'd8;

	// Marker bytes of the image stream.
	localparam logic [7:0] ByteSync = 8'hFF;
	localparam logic [7:0] ByteEnd  = 8'hD9;
	localparam logic [7:0] ByteTail = 8'h76;

	// Command bytes.
	localparam logic [7:0] CmdLead   = 8'h56;
	localparam logic [7:0] CmdCtrl   = 8'h36;
	localparam logic [7:0] CmdLenQ   = 8'h34;
	localparam logic [7:0] CmdRead   = 8'h32;
	localparam logic [7:0] CmdOne    = 8'h01;
	localparam logic [7:0] CmdResume = 8'h03;
	localparam logic [7:0] CmdRdLen  = 8'h0C;
	localparam logic [7:0] CmdRdTail = 8'h0A;

	typedef enum logic [2:0] {
		JobFwd    = 3'd0,
		JobResume = 3'd1,
		JobShot   = 3'd2,
		JobSize   = 3'd3,
		JobRead   = 3'd4
	} job_kind_t;

	// One unit of work handed from the front to the back.
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
		logic [7:0] len_hi;
		logic [7:0] len_lo;
	} job_t;

	function automatic logic [3:0] job_last_idx(input job_kind_t kind);
		logic [3:0] r;
		case (kind)
			JobFwd:  r = 4'd0;
			JobRead: r = 4'd15;
			default: r = 4'd4;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] job_byte(input job_t j, input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		case (j.kind)
			JobFwd: begin
				r = j.data;
			end
			JobResume, JobShot, JobSize: begin
				case (idx)
					4'd0: r = CmdLead;
					4'd2: r = (j.kind == JobSize) ? CmdLenQ : CmdCtrl;
					4'd3: r = CmdOne;
					4'd4: r = (j.kind == JobResume) ? CmdResume : 8'h00;
					default: r = 8'h00;
				endcase
			end
			JobRead: begin
				case (idx)
					4'd0: r = CmdLead;
					4'd2: r = CmdRead;
					4'd3: r = CmdRdLen;
					4'd5: r = CmdRdTail;
					4'd12: r = j.len_hi;
					4'd13: r = j.len_lo;
					4'd15: r = CmdRdTail;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* rtl/scc_front.sv */
module scc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              mode,
	input  logic [7:0]        rx_byte,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [3:0]        wr_data,
	output logic              job_valid,
	output scc_pkg::job_t     job
);

	typedef enum logic [3:0] {
		PhNone = 4'b0001,
		PhIdle = 4'b0010,
		PhShot = 4'b0100,
		PhSize = 4'b1000
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [3:0] idle_wait_q, shot_wait_q;
	logic [3:0] reply_cnt_q, reply_cnt_n;
	logic [3:0] size_idx_q, size_idx_n;
	// Only the two length bytes of the size reply are ever used.
	logic [7:0] len_hi_q, len_hi_n, len_lo_q, len_lo_n;
	logic       capturing_q, capturing_n;
	logic       reading_q, reading_n;
	logic       started_q, started_n;
	logic       saw_end_q, saw_end_n;

	always_comb begin
		phase_n     = phase_q;
		reply_cnt_n = reply_cnt_q;
		size_idx_n  = size_idx_q;
		len_hi_n    = len_hi_q;
		len_lo_n    = len_lo_q;
		capturing_n = capturing_q;
		reading_n   = reading_q;
		started_n   = started_q;
		saw_end_n   = saw_end_q;
		job_valid   = 1'b0;
		job.kind    = scc_pkg::JobFwd;
		job.data    = rx_byte;
		job.len_hi  = len_hi_q;
		job.len_lo  = len_lo_q;

		if (mode) begin
			phase_n     = PhIdle;
			reply_cnt_n = '0;
			size_idx_n  = '0;
			len_hi_n    = '0;
			len_lo_n    = '0;
			capturing_n = 1'b0;
			reading_n   = 1'b0;
			started_n   = 1'b0;
			job_valid   = 1'b1;
			job.kind    = scc_pkg::JobResume;
		end else begin
			if (phase_q != PhNone && reply_cnt_q != scc_pkg::CountMax) begin
				reply_cnt_n = reply_cnt_q + 4'd1;
			end
			if (capturing_q) begin
				if (size_idx_q == scc_pkg::SizeLenHiIdx) begin
					len_hi_n = rx_byte;
				end
				if (size_idx_q == scc_pkg::SizeLenLoIdx) begin
					len_lo_n = rx_byte;
				end
				if (size_idx_q != scc_pkg::CountMax) begin
					size_idx_n = size_idx_q + 4'd1;
				end
			end
			if (rx_byte == scc_pkg::ByteSync) begin
				started_n = 1'b1;
			end
			if (rx_byte == scc_pkg::ByteEnd) begin
				saw_end_n = 1'b1;
			end else if (rx_byte == scc_pkg::ByteTail && saw_end_q) begin
				started_n = 1'b0;
				saw_end_n = 1'b0;
				len_hi_n  = '0;
				len_lo_n  = '0;
			end else begin
				saw_end_n = 1'b0;
			end
			if (reading_q && started_n) begin
				job_valid = 1'b1;
				job.kind  = scc_pkg::JobFwd;
			end
			if (phase_q == PhIdle && reply_cnt_n >= idle_wait_q) begin
				phase_n     = PhShot;
				reply_cnt_n = '0;
				size_idx_n  = '0;
				job_valid   = 1'b1;
				job.kind    = scc_pkg::JobShot;
			end else if (phase_q == PhShot && reply_cnt_n >= shot_wait_q) begin
				phase_n     = PhSize;
				reply_cnt_n = '0;
				capturing_n = 1'b1;
				job_valid   = 1'b1;
				job.kind    = scc_pkg::JobSize;
			end else if (phase_q == PhSize && reply_cnt_n >= scc_pkg::SizeReplyLen) begin
				phase_n     = PhNone;
				reply_cnt_n = '0;
				capturing_n = 1'b0;
				reading_n   = 1'b1;
				started_n   = 1'b0;
				job_valid   = 1'b1;
				job.kind    = scc_pkg::JobRead;
			end
		end
		job.len_hi = len_hi_n;
		job.len_lo = len_lo_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_wait_q <= scc_pkg::IdleWaitRst;
			shot_wait_q <= scc_pkg::ShotWaitRst;
		end else if (wr_en) begin
			if (wr_index == scc_pkg::RegIdleWait) begin
				idle_wait_q <= wr_data;
			end
			if (wr_index == scc_pkg::RegShotWait) begin
				shot_wait_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PhNone;
			reply_cnt_q <= '0;
			size_idx_q  <= '0;
			len_hi_q    <= '0;
			len_lo_q    <= '0;
			capturing_q <= 1'b0;
			reading_q   <= 1'b0;
			started_q   <= 1'b0;
			saw_end_q   <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			reply_cnt_q <= reply_cnt_n;
			size_idx_q  <= size_idx_n;
			len_hi_q    <= len_hi_n;
			len_lo_q    <= len_lo_n;
			capturing_q <= capturing_n;
			reading_q   <= reading_n;
			started_q   <= started_n;
			saw_end_q   <= saw_end_n;
		end
	end

endmodule

/* rtl/scc_jobq.sv */
module scc_jobq #(
	parameter int unsigned Depth = scc_pkg::JobDepthDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  scc_pkg::job_t din,
	output logic          full,
	input  logic          rd,
	output logic          valid,
	output scc_pkg::job_t dout
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	scc_pkg::job_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full  = (cnt_q == CntW'(Depth));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/scc_back.sv */
module scc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  scc_pkg::job_t job,
	output logic          job_pop,
	input  logic          pop,
	output logic          empty,
	output logic          port,
	output logic [7:0]    tx_byte,
	output logic          last
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic       port_q, last_q;
	logic [7:0] byte_q;
	logic       adv, is_last;

	// Emit a byte whenever a job is waiting and the output register is free or being drained.
	assign adv     = job_valid && (!out_valid_q || pop);
	assign is_last = (idx_q == scc_pkg::job_last_idx(job.kind));
	assign job_pop = adv && is_last;

	assign empty   = !out_valid_q;
	assign port    = port_q;
	assign tx_byte = byte_q;
	assign last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			idx_q       <= is_last ? 4'd0 : idx_q + 4'd1;
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			port_q <= (job.kind == scc_pkg::JobFwd);
			byte_q <= scc_pkg::job_byte(job, idx_q);
			last_q <= is_last;
		end
	end

endmodule

/* rtl/serial_camera_capture_sequencer_unit.sv */
// Serial camera capture sequencer. A restart item sends the resume command;
// camera reply bytes are counted to pace the shot command, the size query and
// the 16-byte image read, whose length bytes come from bytes 7 and 8 of the
// size reply. Once the read is out, camera bytes are forwarded to the host
// (port = 1) from the first 0xFF through the 0xD9 of the closing 0xD9 0x76
// pair. Each input item is turned into at most one job (a forwarded byte or
// a command) in a small job queue; the back end expands a job into its result
// bytes at one result per cycle while the output register is drained, so a
// resume, shot or size command expands into 5 result bytes and the image read
// into 16. Input is accepted every cycle while the job queue (JobDepth entries)
// has room; full rises when jobs outpace the result side. last marks the final
// result of each input item. There is no clearing pass after reset; the block
// is ready as soon as reset is released.
module serial_camera_capture_sequencer_unit #(
	parameter int unsigned JobDepth = scc_pkg::JobDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic       port,
	output logic [7:0] tx_byte,
	output logic       last,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [3:0] wr_data
);

	logic          accept;
	logic          fr_job_valid;
	scc_pkg::job_t fr_job;
	logic          jq_push, jq_valid, jq_pop;
	scc_pkg::job_t jq_job;

	// Transfer an item whenever push is high and the job queue has room.
	assign accept  = push && !full;
	// Drop items that cause no result; enqueue the rest.
	assign jq_push = accept && fr_job_valid;

	scc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (mode),
		.rx_byte   (rx_byte),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.job_valid (fr_job_valid),
		.job       (fr_job)
	);

	scc_jobq #(
		.Depth (JobDepth)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (jq_push),
		.din    (fr_job),
		.full   (full),
		.rd     (jq_pop),
		.valid  (jq_valid),
		.dout   (jq_job)
	);

	scc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (jq_valid),
		.job       (jq_job),
		.job_pop   (jq_pop),
		.pop       (pop),
		.empty     (empty),
		.port      (port),
		.tx_byte   (tx_byte),
		.last      (last)
	);

	// Never retire a job that is not there.
	assert property (@(posedge clk) disable iff (!arst_n) jq_pop |-> jq_valid)
		else $error("job retired from empty queue");

	// A restart always leaves work behind for the result side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode) |=> (jq_valid || !empty))
		else $error("restart produced no pending result");

	// A forwarded byte is always the only result of its job.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && port) |-> last)
		else $error("forwarded byte without last");

endmodule
